// ===== design/bfha_pkg.sv =====
// Shared types and constants for the best-fit hole allocator.
// Holds no dependencies; every other design file refers to it by scoped names.
`default_nettype none

package bfha_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int ADDR_W           = 24;
  localparam int OWNER_W          = 16;
  localparam int STATUS_W         = 3;

  localparam logic [ADDR_W-1:0]  MEM_SIZE_RESET = 24'd65536;
  localparam logic [OWNER_W-1:0] FIRST_OWNER_ID = 16'd1000;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXACT     = 3'd0,
    ST_SPLIT     = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_FREED     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } res_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_END,
    S_WR_LEFT,
    S_WR_PICK,
    S_RESP
  } ctl_state_t;

  // One table entry.
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  size;
    logic [OWNER_W-1:0] owner;
    logic               used;
  } seg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic accept;
    logic scan_rd;
    logic decide;
    logic shift_rd;
    logic wr_left;
    logic wr_pick;
    logic load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic        idx_last;
    logic        shift_last;
    logic        pick_last;
    logic        out_free;
    res_status_t outcome;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/best_fit_hole_allocator_core.sv =====
// Top level of the best-fit hole allocator: controller plus datapath.
// Depends on bfha_pkg, bfha_ctrl, bfha_datapath and bfha_table.
//
// The block manages an ordered table of up to MAX_SEGMENTS memory segments,
// held in a single-port-write, registered-read memory. An allocate word picks
// the smallest free segment that fits (lowest index on ties); an exact fit is
// marked used, a larger one is split with the remainder inserted right after
// it, and the new block receives the next owner id, starting at 1000 and
// wrapping at 16 bits. A free word releases the first used segment with the
// given owner id; free segments are never merged. Writing cfg_wdata with
// cfg_we high loads the memory size and rebuilds the table as one free
// segment at base 0 (the owner id counter is kept); no input word is taken in
// the cycle of the write nor in the rebuild cycle that follows it, and the
// same rebuild cycle runs once after reset. Words are handled one at a time.
// The best-fit scan reads every entry through the memory's single read port,
// then the decision follows. A no fit, table full or unknown id goes
// straight to the result; an exact fit or a free writes the picked entry
// first, and a split of the last entry writes the remainder entry and then
// the picked one. A split of an entry below the last one first moves the
// later entries up one place through the same port before those writes;
// the scan and the entry move each go through it one entry per cycle. The
// next word is taken in the cycle after the load at the earliest. A finished
// result word sits in the output register and the block takes the next
// input word while it waits there; a result word still stalled there holds
// back the load of the following one.
`default_nettype none

module best_fit_hole_allocator_core #(
  parameter int MAX_SEGMENTS = bfha_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration port for the memory size register.
  input  wire logic                            cfg_we,
  input  wire logic [bfha_pkg::ADDR_W-1:0]     cfg_wdata,
  // Command channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_cmd,
  input  wire logic [bfha_pkg::ADDR_W-1:0]     in_request_size,
  input  wire logic [bfha_pkg::OWNER_W-1:0]    in_owner_id,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bfha_pkg::STATUS_W-1:0]        out_status,
  output logic [bfha_pkg::OWNER_W-1:0]         out_assigned_id,
  output logic [bfha_pkg::ADDR_W-1:0]          out_block_base,
  output logic [bfha_pkg::ADDR_W-1:0]          out_block_size,
  output logic [bfha_pkg::ADDR_W-1:0]          out_leftover_base,
  output logic [bfha_pkg::ADDR_W-1:0]          out_leftover_size
);

  // Command and status bundles between the sequencer and the datapath.
  bfha_pkg::ctl_cmd_t   ctl;
  bfha_pkg::dp_status_t sts;

  // The controller walks each word through scan, decision, optional entry
  // move, table writes and the result hand-off.
  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  // The datapath holds the table, the best-fit search registers, the segment
  // count, the owner id counter and the result register.
  bfha_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_request_size   (in_request_size),
    .in_owner_id       (in_owner_id),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_assigned_id   (out_assigned_id),
    .out_block_base    (out_block_base),
    .out_block_size    (out_block_size),
    .out_leftover_base (out_leftover_base),
    .out_leftover_size (out_leftover_size)
  );

endmodule

`default_nettype wire

// ===== design/bfha_table.sv =====
// Segment table storage: one write port and one registered read port.
// Depends on bfha_pkg for the entry type.
`default_nettype none

module bfha_table #(
  parameter int DEPTH = bfha_pkg::MAX_SEGMENTS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire bfha_pkg::seg_t  wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output bfha_pkg::seg_t       rdata
);

  bfha_pkg::seg_t mem [DEPTH];
  bfha_pkg::seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bfha_ctrl.sv =====
// Controller state machine of the allocator: sequences scan, shift and writes.
// Depends on bfha_pkg for the state, command and status types.
`default_nettype none

module bfha_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 cfg_we,
  input  wire bfha_pkg::dp_status_t sts,
  output logic                      in_stall,
  output bfha_pkg::ctl_cmd_t        ctl
);

  bfha_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfha_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfha_pkg::S_INIT:      state_nxt = bfha_pkg::S_IDLE;
      bfha_pkg::S_IDLE:      if (in_valid) state_nxt = bfha_pkg::S_SCAN;
      bfha_pkg::S_SCAN:      if (sts.idx_last) state_nxt = bfha_pkg::S_SCAN_END;
      bfha_pkg::S_SCAN_END:  state_nxt = bfha_pkg::S_DECIDE;
      bfha_pkg::S_DECIDE: begin
        case (sts.outcome)
          bfha_pkg::ST_EXACT, bfha_pkg::ST_FREED: state_nxt = bfha_pkg::S_WR_PICK;
          bfha_pkg::ST_SPLIT:
            state_nxt = sts.pick_last ? bfha_pkg::S_WR_LEFT : bfha_pkg::S_SHIFT;
          default: state_nxt = bfha_pkg::S_RESP;
        endcase
      end
      bfha_pkg::S_SHIFT:     if (sts.shift_last) state_nxt = bfha_pkg::S_SHIFT_END;
      bfha_pkg::S_SHIFT_END: state_nxt = bfha_pkg::S_WR_LEFT;
      bfha_pkg::S_WR_LEFT:   state_nxt = bfha_pkg::S_WR_PICK;
      bfha_pkg::S_WR_PICK:   state_nxt = bfha_pkg::S_RESP;
      bfha_pkg::S_RESP:      if (sts.out_free) state_nxt = bfha_pkg::S_IDLE;
      default:               state_nxt = bfha_pkg::S_INIT;
    endcase
    // A register write rebuilds the table; the user must only write it while idle, the block does not enforce this.
    if (cfg_we) begin
      state_nxt = bfha_pkg::S_INIT;
    end
  end

  always_comb begin
    ctl          = '0;
    in_stall     = (state_r != bfha_pkg::S_IDLE) || cfg_we;
    ctl.init     = (state_r == bfha_pkg::S_INIT);
    ctl.accept   = (state_r == bfha_pkg::S_IDLE) && in_valid && !cfg_we;
    ctl.scan_rd  = (state_r == bfha_pkg::S_SCAN);
    ctl.decide   = (state_r == bfha_pkg::S_DECIDE);
    ctl.shift_rd = (state_r == bfha_pkg::S_SHIFT);
    ctl.wr_left  = (state_r == bfha_pkg::S_WR_LEFT);
    ctl.wr_pick  = (state_r == bfha_pkg::S_WR_PICK);
    ctl.load     = (state_r == bfha_pkg::S_RESP) && sts.out_free;
  end

endmodule

`default_nettype wire

// ===== design/bfha_datapath.sv =====
// Datapath of the allocator: segment table, scan compare, shift pipe and result register.
// Depends on bfha_pkg and bfha_table.
`default_nettype none

module bfha_datapath #(
  parameter int MAX_SEGMENTS = bfha_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bfha_pkg::ctl_cmd_t              ctl,
  output bfha_pkg::dp_status_t                 sts,
  input  wire logic                            cfg_we,
  input  wire logic [bfha_pkg::ADDR_W-1:0]     cfg_wdata,
  input  wire logic                            in_cmd,
  input  wire logic [bfha_pkg::ADDR_W-1:0]     in_request_size,
  input  wire logic [bfha_pkg::OWNER_W-1:0]    in_owner_id,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic [bfha_pkg::STATUS_W-1:0]        out_status,
  output logic [bfha_pkg::OWNER_W-1:0]         out_assigned_id,
  output logic [bfha_pkg::ADDR_W-1:0]          out_block_base,
  output logic [bfha_pkg::ADDR_W-1:0]          out_block_size,
  output logic [bfha_pkg::ADDR_W-1:0]          out_leftover_base,
  output logic [bfha_pkg::ADDR_W-1:0]          out_leftover_size
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int AW    = bfha_pkg::ADDR_W;
  localparam int OW    = bfha_pkg::OWNER_W;

  logic [AW-1:0]        mem_size_r;
  logic [CNT_W-1:0]     count_r;
  logic [OW-1:0]        next_id_r;
  bfha_pkg::op_t        op_r;
  logic [AW-1:0]        req_r;
  logic [OW-1:0]        id_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 cmp_v_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [AW-1:0]        pick_base_r;
  logic [AW-1:0]        best_r;
  logic                 sh_v_r;
  logic [IDX_W-1:0]     sh_dst_r;
  bfha_pkg::res_status_t outcome_r, outcome;

  logic                 out_valid_r;
  logic [bfha_pkg::STATUS_W-1:0] status_r;
  logic [OW-1:0]        assigned_id_r;
  logic [AW-1:0]        block_base_r, block_size_r, left_base_r, left_size_r;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  bfha_pkg::seg_t       wr_data;
  bfha_pkg::seg_t       rd_data;
  logic                 hit;
  logic [CNT_W-1:0]     count_m1;

  bfha_table #(
    .DEPTH (MAX_SEGMENTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  assign count_m1 = count_r - CNT_W'(1);

  // Best fit keeps the first smallest candidate; free keeps the first owner match.
  always_comb begin
    if (op_r == bfha_pkg::OP_ALLOC) begin
      hit = cmp_v_r && !rd_data.used && (rd_data.size >= req_r) &&
            (!found_r || (rd_data.size < best_r));
    end else begin
      hit = cmp_v_r && rd_data.used && (rd_data.owner == id_r) && !found_r;
    end
  end

  always_comb begin
    if (op_r == bfha_pkg::OP_FREE) begin
      outcome = found_r ? bfha_pkg::ST_FREED : bfha_pkg::ST_NOT_FOUND;
    end else if ((req_r == '0) || !found_r) begin
      outcome = bfha_pkg::ST_NO_FIT;
    end else if (best_r == req_r) begin
      outcome = bfha_pkg::ST_EXACT;
    end else if (count_r == CNT_W'(MAX_SEGMENTS)) begin
      outcome = bfha_pkg::ST_FULL;
    end else begin
      outcome = bfha_pkg::ST_SPLIT;
    end
  end

  // One table write per cycle; the shift pipe owns the port while it runs.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (sh_v_r) begin
      wr_en   = 1'b1;
      wr_addr = sh_dst_r;
      wr_data = rd_data;
    end else if (ctl.wr_left) begin
      wr_en         = 1'b1;
      wr_addr       = pick_r + IDX_W'(1);
      wr_data.base  = pick_base_r + req_r;
      wr_data.size  = best_r - req_r;
      wr_data.owner = '0;
      wr_data.used  = 1'b0;
    end else if (ctl.wr_pick) begin
      wr_en         = 1'b1;
      wr_addr       = pick_r;
      wr_data.base  = pick_base_r;
      wr_data.size  = (op_r == bfha_pkg::OP_ALLOC) ? req_r : best_r;
      wr_data.owner = (op_r == bfha_pkg::OP_ALLOC) ? next_id_r : id_r;
      wr_data.used  = (op_r == bfha_pkg::OP_ALLOC);
    end else if (ctl.init) begin
      wr_en         = 1'b1;
      wr_addr       = '0;
      wr_data.size  = mem_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= bfha_pkg::MEM_SIZE_RESET;
      count_r    <= CNT_W'(1);
      next_id_r  <= bfha_pkg::FIRST_OWNER_ID;
      cmp_v_r    <= 1'b0;
      sh_v_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        mem_size_r <= cfg_wdata;
      end
      if (ctl.init) begin
        count_r <= CNT_W'(1);
      end else if (ctl.wr_left) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (ctl.load && ((outcome_r == bfha_pkg::ST_EXACT) ||
                       (outcome_r == bfha_pkg::ST_SPLIT))) begin
        next_id_r <= next_id_r + OW'(1);
      end
      cmp_v_r <= ctl.scan_rd;
      sh_v_r  <= ctl.shift_rd;
      if (ctl.accept) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r  <= bfha_pkg::op_t'(in_cmd);
      req_r <= in_request_size;
      id_r  <= in_owner_id;
      idx_r <= '0;
    end else if (ctl.scan_rd) begin
      idx_r <= idx_r + IDX_W'(1);
    end else if (ctl.decide) begin
      idx_r <= count_m1[IDX_W-1:0];
    end else if (ctl.shift_rd) begin
      idx_r <= idx_r - IDX_W'(1);
    end
    cmp_idx_r <= idx_r;
    sh_dst_r  <= idx_r + IDX_W'(1);
    if (hit) begin
      pick_r      <= cmp_idx_r;
      pick_base_r <= rd_data.base;
      best_r      <= rd_data.size;
    end
    if (ctl.decide) begin
      outcome_r <= outcome;
    end
  end

  // Result register: a new word may load as the previous one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      status_r      <= outcome_r;
      assigned_id_r <= '0;
      block_base_r  <= '0;
      block_size_r  <= '0;
      left_base_r   <= '0;
      left_size_r   <= '0;
      case (outcome_r)
        bfha_pkg::ST_EXACT: begin
          assigned_id_r <= next_id_r;
          block_base_r  <= pick_base_r;
          block_size_r  <= req_r;
        end
        bfha_pkg::ST_SPLIT: begin
          assigned_id_r <= next_id_r;
          block_base_r  <= pick_base_r;
          block_size_r  <= req_r;
          left_base_r   <= pick_base_r + req_r;
          left_size_r   <= best_r - req_r;
        end
        bfha_pkg::ST_FREED: begin
          assigned_id_r <= id_r;
          block_base_r  <= pick_base_r;
          block_size_r  <= best_r;
        end
        bfha_pkg::ST_NOT_FOUND: begin
          assigned_id_r <= id_r;
        end
        default: begin
          assigned_id_r <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts            = '0;
    sts.idx_last   = (CNT_W'(idx_r) == count_m1);
    sts.shift_last = (idx_r == (pick_r + IDX_W'(1)));
    sts.pick_last  = (CNT_W'(pick_r) == count_m1);
    sts.out_free   = !out_valid_r || !out_stall;
    sts.outcome    = outcome;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_assigned_id   = assigned_id_r;
  assign out_block_base    = block_base_r;
  assign out_block_size    = block_size_r;
  assign out_leftover_base = left_base_r;
  assign out_leftover_size = left_size_r;

endmodule

`default_nettype wire

// ===== bench/tb_best_fit_hole_allocator_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_hole_allocator_core: directed table and
// random phases, all scored against an in-bench best-fit table predictor.
// Depends only on bfha_pkg and the core itself.

module tb_best_fit_hole_allocator_core;

  localparam int SEG_DEPTH = bfha_pkg::MAX_SEGMENTS_DEF;
  localparam int ADDR_W    = bfha_pkg::ADDR_W;
  localparam int OWNER_W   = bfha_pkg::OWNER_W;
  localparam int STATUS_W  = bfha_pkg::STATUS_W;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int HANG_LIMIT = 5000;

  // One command word and one result word, in the field widths of the ports.
  typedef struct packed {
    bfha_pkg::op_t      op;
    logic [ADDR_W-1:0]  req;
    logic [OWNER_W-1:0] owner;
  } alloc_cmd_t;

  typedef struct packed {
    bfha_pkg::res_status_t status;
    logic [OWNER_W-1:0]    id;
    logic [ADDR_W-1:0]     base;
    logic [ADDR_W-1:0]     size;
    logic [ADDR_W-1:0]     left_base;
    logic [ADDR_W-1:0]     left_size;
  } alloc_reply_t;

  // A row of the directed table: either a memory size write or a command word,
  // the latter optionally with its result typed in by hand.
  typedef struct packed {
    bit                is_cfg;
    logic [ADDR_W-1:0] mem_size;
    alloc_cmd_t        word;
    bit                fixed;
    alloc_reply_t      reply;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [ADDR_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic                in_cmd;
  logic [ADDR_W-1:0]   in_request_size;
  logic [OWNER_W-1:0]  in_owner_id;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [OWNER_W-1:0]  out_assigned_id;
  logic [ADDR_W-1:0]   out_block_base;
  logic [ADDR_W-1:0]   out_block_size;
  logic [ADDR_W-1:0]   out_leftover_base;
  logic [ADDR_W-1:0]   out_leftover_size;

  best_fit_hole_allocator_core #(
    .MAX_SEGMENTS(SEG_DEPTH)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_request_size  (in_request_size),
    .in_owner_id      (in_owner_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_assigned_id  (out_assigned_id),
    .out_block_base   (out_block_base),
    .out_block_size   (out_block_size),
    .out_leftover_base(out_leftover_base),
    .out_leftover_size(out_leftover_size)
  );

  always #10 clk = ~clk;

  // Predicted segment table. It mirrors what the block should hold after every
  // accepted word; the owner id counter survives a memory size write.
  logic [ADDR_W-1:0]  hole_base  [SEG_DEPTH];
  logic [ADDR_W-1:0]  hole_size  [SEG_DEPTH];
  logic [OWNER_W-1:0] hole_owner [SEG_DEPTH];
  bit                 hole_used  [SEG_DEPTH];
  int                 hole_count;
  logic [OWNER_W-1:0] owner_next;

  // Results still owed by the block, oldest first.
  alloc_reply_t replies_due[$];

  int  faults;
  int  words_in;
  int  size_writes;
  int  tally[6];
  int  quiet_cycles;
  // When set, neither side inserts idle cycles or stalls.
  bit  calm;

  // A memory size write leaves one free segment at base 0 covering everything.
  function automatic void table_rebuild(input logic [ADDR_W-1:0] total);
    for (int i = 0; i < SEG_DEPTH; i++) begin
      hole_base[i]  = '0;
      hole_size[i]  = '0;
      hole_owner[i] = '0;
      hole_used[i]  = 1'b0;
    end
    hole_size[0] = total;
    hole_count   = 1;
  endfunction

  // Applies one command word to the predicted table and returns the result word
  // the block must produce for it.
  function automatic alloc_reply_t place_or_release(input alloc_cmd_t w);
    alloc_reply_t      r;
    int                pick;
    bit                found;
    logic [ADDR_W-1:0] best;

    r     = '0;
    pick  = 0;
    found = 1'b0;
    best  = '0;
    if (w.op == bfha_pkg::OP_ALLOC) begin
      r.status = bfha_pkg::ST_NO_FIT;
      if (w.req != '0) begin
        // Smallest free segment that holds the request; the earliest wins a tie.
        for (int i = 0; i < hole_count; i++) begin
          if (!hole_used[i] && hole_size[i] >= w.req && (!found || hole_size[i] < best)) begin
            found = 1'b1;
            pick  = i;
            best  = hole_size[i];
          end
        end
      end
      if (found && hole_size[pick] == w.req) begin
        hole_used[pick]  = 1'b1;
        hole_owner[pick] = owner_next;
        r.status = bfha_pkg::ST_EXACT;
      end else if (found && hole_count >= SEG_DEPTH) begin
        // A split would need one more entry than the table has.
        r.status = bfha_pkg::ST_FULL;
        found    = 1'b0;
      end else if (found) begin
        for (int i = hole_count; i > pick + 1; i--) begin
          hole_base[i]  = hole_base[i-1];
          hole_size[i]  = hole_size[i-1];
          hole_owner[i] = hole_owner[i-1];
          hole_used[i]  = hole_used[i-1];
        end
        hole_count++;
        hole_base[pick+1]  = hole_base[pick] + w.req;
        hole_size[pick+1]  = hole_size[pick] - w.req;
        hole_owner[pick+1] = '0;
        hole_used[pick+1]  = 1'b0;
        hole_size[pick]    = w.req;
        hole_used[pick]    = 1'b1;
        hole_owner[pick]   = owner_next;
        r.status    = bfha_pkg::ST_SPLIT;
        r.left_base = hole_base[pick+1];
        r.left_size = hole_size[pick+1];
      end
      if (found) begin
        r.id       = owner_next;
        r.base     = hole_base[pick];
        r.size     = hole_size[pick];
        owner_next = owner_next + 1'b1;
      end
    end else begin
      r.id     = w.owner;
      r.status = bfha_pkg::ST_NOT_FOUND;
      for (int i = 0; i < hole_count; i++) begin
        if (!found && hole_used[i] && hole_owner[i] == w.owner) begin
          found        = 1'b1;
          hole_used[i] = 1'b0;
          r.status     = bfha_pkg::ST_FREED;
          r.base       = hole_base[i];
          r.size       = hole_size[i];
        end
      end
    end
    return r;
  endfunction

  // Random index of a predicted entry whose used mark equals want, or -1.
  function automatic int pick_entry(input bit want);
    int n;
    int k;
    int sel;

    n   = 0;
    sel = -1;
    for (int i = 0; i < hole_count; i++)
      if (hole_used[i] == want) n++;
    if (n > 0) begin
      k = $urandom_range(0, n - 1);
      for (int i = 0; i < hole_count; i++) begin
        if (hole_used[i] == want) begin
          if (k == 0) sel = i;
          k--;
        end
      end
    end
    return sel;
  endfunction

  // Random command word. Most words are allocations scaled to the memory size,
  // exact fits of a current hole and frees of ids really held, so the table gets
  // deep; the rest are unknown ids, oversized and zero requests.
  function automatic alloc_cmd_t draw_word(input logic [ADDR_W-1:0] span);
    alloc_cmd_t w;
    int         roll;
    int         idx;
    int         cap;

    cap     = (span >> 4) == 0 ? 1 : int'(span >> 4);
    roll    = $urandom_range(0, 99);
    w.op    = bfha_pkg::OP_ALLOC;
    w.owner = OWNER_W'($urandom_range(0, 65535));
    w.req   = ADDR_W'($urandom_range(1, cap));
    if (roll >= 45 && roll < 58) begin
      idx = pick_entry(1'b0);
      if (idx >= 0) w.req = hole_size[idx];
    end else if (roll >= 58 && roll < 85) begin
      w.op = bfha_pkg::OP_FREE;
      idx  = pick_entry(1'b1);
      if (idx >= 0) w.owner = hole_owner[idx];
    end else if (roll >= 85 && roll < 92) begin
      w.op = bfha_pkg::OP_FREE;
    end else if (roll >= 92 && roll < 98) begin
      w.req = ADDR_W'($urandom_range(0, 24'hFFFFFF));
    end else if (roll >= 98) begin
      w.req = '0;
    end
    return w;
  endfunction

  function automatic plan_row_t row_cmd(input bfha_pkg::op_t op,
                                        input logic [ADDR_W-1:0] req,
                                        input logic [OWNER_W-1:0] owner);
    plan_row_t p;

    p            = '0;
    p.word.op    = op;
    p.word.req   = req;
    p.word.owner = owner;
    return p;
  endfunction

  function automatic plan_row_t row_lit(input bfha_pkg::op_t op,
                                        input logic [ADDR_W-1:0] req,
                                        input logic [OWNER_W-1:0] owner,
                                        input bfha_pkg::res_status_t st,
                                        input logic [OWNER_W-1:0] id,
                                        input logic [ADDR_W-1:0] base,
                                        input logic [ADDR_W-1:0] size,
                                        input logic [ADDR_W-1:0] left_base,
                                        input logic [ADDR_W-1:0] left_size);
    plan_row_t p;

    p                 = row_cmd(op, req, owner);
    p.fixed           = 1'b1;
    p.reply.status    = st;
    p.reply.id        = id;
    p.reply.base      = base;
    p.reply.size      = size;
    p.reply.left_base = left_base;
    p.reply.left_size = left_size;
    return p;
  endfunction

  function automatic plan_row_t row_size(input logic [ADDR_W-1:0] total);
    plan_row_t p;

    p          = '0;
    p.is_cfg   = 1'b1;
    p.mem_size = total;
    return p;
  endfunction

  // Offers one command word and returns at the edge where it is taken. The
  // expected result is worked out at that edge, so the predicted table always
  // follows the order in which the block sees words.
  task automatic push_word(input alloc_cmd_t w, input bit fixed, input alloc_reply_t lit);
    alloc_reply_t r;

    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= w.op;
    in_request_size <= w.req;
    in_owner_id     <= w.owner;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = place_or_release(w);
    if (fixed) r = lit;
    replies_due.push_back(r);
    tally[int'(r.status)]++;
    words_in++;
  endtask

  // Drops valid and waits until the block owes nothing, so it is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [ADDR_W-1:0] total);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= total;
    table_rebuild(total);
    size_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string tag, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t ns: %s expected %0d, got %0d", $time, tag, want, got);
    end
  endtask

  task automatic take_reply();
    alloc_reply_t want;

    if (replies_due.size() == 0) begin
      faults++;
      $display("%0t ns: result word with nothing pending: expected none, got status %0d id %0d",
               $time, out_status, out_assigned_id);
    end else begin
      want = replies_due.pop_front();
      check_field("status", ADDR_W'(want.status), ADDR_W'(out_status));
      check_field("assigned_id", ADDR_W'(want.id), ADDR_W'(out_assigned_id));
      check_field("block_base", want.base, out_block_base);
      check_field("block_size", want.size, out_block_size);
      check_field("leftover_base", want.left_base, out_leftover_base);
      check_field("leftover_size", want.left_size, out_leftover_size);
    end
  endtask

  // Result side: score every word taken, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) take_reply();
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  // Hang detection: any handshake or register write restarts the count.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
        || cfg_we === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == HANG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, HANG_LIMIT, replies_due.size());
      $display("best_fit_hole_allocator_core: mismatch");
      $finish;
    end
  end

  initial begin
    plan_row_t         plan[$];
    logic [ADDR_W-1:0] phase_size[6];

    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_cmd          = 1'b0;
    in_request_size = '0;
    in_owner_id     = '0;
    out_stall       = 1'b0;
    calm            = 1'b0;
    faults          = 0;
    words_in        = 0;
    size_writes     = 0;
    quiet_cycles    = 0;
    foreach (tally[i]) tally[i] = 0;
    owner_next = bfha_pkg::FIRST_OWNER_ID;
    table_rebuild(bfha_pkg::MEM_SIZE_RESET);

    // Directed table. The first rows run on the reset memory size of 65536 and
    // the first owner id of 1000, so their results can be written down directly.
    // Zero request and a request beyond the memory are both plain no-fit words.
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'd0, 16'd0, bfha_pkg::ST_NO_FIT, 16'd0,
                           24'd0, 24'd0, 24'd0, 24'd0));
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'd65537, 16'd0, bfha_pkg::ST_NO_FIT, 16'd0,
                           24'd0, 24'd0, 24'd0, 24'd0));
    // Nothing is held yet, so a free finds nobody.
    plan.push_back(row_lit(bfha_pkg::OP_FREE, 24'd0, 16'd1000, bfha_pkg::ST_NOT_FOUND, 16'd1000,
                           24'd0, 24'd0, 24'd0, 24'd0));
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'd100, 16'd0, bfha_pkg::ST_SPLIT, 16'd1000,
                           24'd0, 24'd100, 24'd100, 24'd65436));
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'd65436, 16'd0, bfha_pkg::ST_EXACT, 16'd1001,
                           24'd100, 24'd65436, 24'd0, 24'd0));
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'd1, 16'd0, bfha_pkg::ST_NO_FIT, 16'd0,
                           24'd0, 24'd0, 24'd0, 24'd0));
    plan.push_back(row_lit(bfha_pkg::OP_FREE, 24'd0, 16'd1000, bfha_pkg::ST_FREED, 16'd1000,
                           24'd0, 24'd100, 24'd0, 24'd0));
    // The same id again: the segment is free now and free segments never match.
    plan.push_back(row_lit(bfha_pkg::OP_FREE, 24'd0, 16'd1000, bfha_pkg::ST_NOT_FOUND, 16'd1000,
                           24'd0, 24'd0, 24'd0, 24'd0));
    plan.push_back(row_lit(bfha_pkg::OP_FREE, 24'hFFFFFF, 16'hFFFF, bfha_pkg::ST_NOT_FOUND,
                           16'hFFFF, 24'd0, 24'd0, 24'd0, 24'd0));
    // Split then exact fit inside the freed hole, then free all three blocks so
    // that holes of 40, 60 and 65436 sit in that order. A request of 50 must go
    // to the 60 hole, not the first or the largest one; 10 then fills its rest.
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd40, 16'd0));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd60, 16'd0));
    plan.push_back(row_cmd(bfha_pkg::OP_FREE, 24'd0, 16'd1001));
    plan.push_back(row_cmd(bfha_pkg::OP_FREE, 24'd0, 16'd1002));
    plan.push_back(row_cmd(bfha_pkg::OP_FREE, 24'd0, 16'd1003));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd50, 16'd0));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd10, 16'd0));
    // Two equal holes of 10: the lower entry must win the tie.
    plan.push_back(row_size(24'd30));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd10, 16'd0));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd10, 16'd0));
    plan.push_back(row_cmd(bfha_pkg::OP_FREE, 24'd0, 16'd1006));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd10, 16'd0));
    // A memory of size zero fits nothing.
    plan.push_back(row_size(24'd0));
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'd1, 16'd0, bfha_pkg::ST_NO_FIT, 16'd0,
                           24'd0, 24'd0, 24'd0, 24'd0));
    // Largest memory: a split that leaves one unit at the very top, which is
    // then taken as an exact fit; after that even the full size has no room.
    plan.push_back(row_size(24'hFFFFFF));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'hFFFFFE, 16'd0));
    plan.push_back(row_cmd(bfha_pkg::OP_ALLOC, 24'd1, 16'hFFFF));
    plan.push_back(row_lit(bfha_pkg::OP_ALLOC, 24'hFFFFFF, 16'd0, bfha_pkg::ST_NO_FIT, 16'd0,
                           24'd0, 24'd0, 24'd0, 24'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        write_size(plan[k].mem_size);
      end else begin
        push_word(plan[k].word, plan[k].fixed, plan[k].reply);
      end
    end

    // Random phases over several memory sizes. Small memories fill all table
    // entries, so table-full words show up; one phase runs without any idling.
    phase_size[0] = 24'd200;
    phase_size[1] = 24'hFFFFFF;
    phase_size[2] = 24'd64;
    phase_size[3] = 24'd1;
    phase_size[4] = bfha_pkg::MEM_SIZE_RESET;
    phase_size[5] = ADDR_W'($urandom_range(2, 24'hFFFFFF));
    for (int ph = 0; ph < 6; ph++) begin
      write_size(phase_size[ph]);
      calm = (ph == 2);
      repeat (200) push_word(draw_word(phase_size[ph]), 1'b0, '0);
    end
    calm = 1'b0;

    // Drain, then leave room for any stray result word to show up.
    settle();
    repeat (2 * SEG_DEPTH + 8) @(posedge clk);

    $display("Ran %0d command words across %0d memory size writes, directed and random.",
             words_in, size_writes);
    $display("Outcomes: %0d exact, %0d split, %0d no fit, %0d table full, %0d freed, %0d unknown id.",
             tally[bfha_pkg::ST_EXACT], tally[bfha_pkg::ST_SPLIT], tally[bfha_pkg::ST_NO_FIT],
             tally[bfha_pkg::ST_FULL], tally[bfha_pkg::ST_FREED], tally[bfha_pkg::ST_NOT_FOUND]);
    if (faults == 0) begin
      $display("best_fit_hole_allocator_core: match");
    end else begin
      $display("best_fit_hole_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
